@@ sv/mpq_pkg.sv @@
// Shared types and constants for the max priority queue block.
// Depends on nothing; the core, the checker and the testbench import it.
`default_nettype none

package mpq_pkg;

  // Fixed field widths of the command and result items.
  localparam int unsigned KEY_W = 32;
  localparam int unsigned PAY_W = 16;
  localparam int unsigned OCC_W = 7;

  // Defaults for the top-level parameters.
  localparam int unsigned DEF_CAPACITY     = 64;
  localparam int unsigned DEF_PAYLOAD_BITS = 16;

  // Command codes.
  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_EXTRACTED = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE     = 2'd0,
    S_INS_RD   = 2'd1,
    S_INS_CMP  = 2'd2,
    S_EXT_DATA = 2'd3
  } state_e;

  typedef struct packed {
    logic                     command;
    logic signed [KEY_W-1:0]  key;
    logic        [PAY_W-1:0]  payload;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [KEY_W-1:0]  out_key;
    logic        [PAY_W-1:0]  out_payload;
    logic        [OCC_W-1:0]  occupancy;
  } out_item_t;

endpackage

`default_nettype wire

@@ sv/mpq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used for the entry store of the priority queue.
`default_nettype none

module mpq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ sv/max_priority_queue_core.sv @@
// Max priority queue core: a sorted entry store in one synchronous RAM.
// Depends on mpq_pkg and mpq_ram.
//
// Usage:
//   A command item is taken on a rising edge where start_i is high and busy_o
//   is low. An insert stores (key, payload); an extract removes the entry with
//   the largest signed key, the most recently inserted one among equal keys.
//   Every command produces exactly one result item on result_o, marked by a
//   one-cycle done_o strobe. The receiver cannot stall, so the result must be
//   taken in that cycle; a new command may be issued while done_o is high.
//
//   The entries are kept in RAM sorted ascending, the maximum at the address
//   just below the entry count. An extract reads that address; the RAM
//   registers the read data and S_EXT_DATA loads it into the result. An insert
//   walks down from the top, moving each larger entry up by one address: every
//   entry moved passes S_INS_RD (RAM read, registered data), then S_INS_CMP
//   (compare and write). The new entry is written in S_INS_CMP above the first
//   entry that is not larger, or in S_INS_RD at the lowest address. An extract
//   from an empty queue or an insert into a full queue is answered on the cycle
//   after the command without touching the RAM.
//
//   Reset clears the entry count and the control state; the RAM is not
//   cleared, as only data from addresses below the count is ever used.
`default_nettype none

module max_priority_queue_core #(
  parameter int unsigned CAPACITY     = mpq_pkg::DEF_CAPACITY,
  parameter int unsigned PAYLOAD_BITS = mpq_pkg::DEF_PAYLOAD_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  mpq_pkg::in_item_t  item_i,
  output logic               busy_o,
  output logic               done_o,
  output mpq_pkg::out_item_t result_o
);

  import mpq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = KEY_W + PAYLOAD_BITS;

  // Control state.
  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic           done_q, done_d;

  // Working registers of the insert walk and the result register.
  logic [AW-1:0]            pos_q, pos_d;
  logic signed [KEY_W-1:0]  key_q, key_d;
  logic [PAYLOAD_BITS-1:0]  pay_q, pay_d;
  out_item_t                res_q, res_d;

  // RAM port signals.
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [EW-1:0]  ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [EW-1:0]  ram_rdata;

  // Derived values.
  logic                     accept;
  logic                     is_empty;
  logic                     is_full;
  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            pos_m1;
  logic signed [KEY_W-1:0]  rd_key;
  logic [63:0]              rd_pay_ext;
  logic [63:0]              in_pay_ext;
  logic                     rd_larger;

  assign accept     = start_i && (state_q == S_IDLE);
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CW'(CAPACITY));
  assign cnt_m1     = count_q - CW'(1);
  assign pos_m1     = pos_q - AW'(1);
  assign rd_key     = $signed(ram_rdata[EW-1:PAYLOAD_BITS]);
  assign rd_pay_ext = 64'(ram_rdata[PAYLOAD_BITS-1:0]);
  assign in_pay_ext = 64'(item_i.payload);
  // The stored entry moves up only when strictly larger, so a new entry lands
  // above every equal key and leaves before them.
  assign rd_larger  = (rd_key > key_q);

  mpq_ram #(
    .WIDTH (EW),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.command == CMD_INSERT) begin
            state_d = is_full ? S_IDLE : S_INS_RD;
          end else begin
            state_d = is_empty ? S_IDLE : S_EXT_DATA;
          end
        end
      end
      S_INS_RD: begin
        state_d = (pos_q == '0) ? S_IDLE : S_INS_CMP;
      end
      S_INS_CMP: begin
        state_d = rd_larger ? S_INS_RD : S_IDLE;
      end
      S_EXT_DATA: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath, RAM access and result logic.
  always_comb begin
    count_d   = count_q;
    pos_d     = pos_q;
    key_d     = key_q;
    pay_d     = pay_q;
    done_d    = 1'b0;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = {key_q, pay_q};
    ram_raddr = pos_m1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_d = item_i.key;
          pay_d = in_pay_ext[PAYLOAD_BITS-1:0];
          pos_d = count_q[AW-1:0];
          res_d.out_key     = '0;
          res_d.out_payload = '0;
          if (item_i.command == CMD_INSERT) begin
            if (is_full) begin
              done_d       = 1'b1;
              res_d.status = ST_FULL;
            end
          end else if (is_empty) begin
            done_d       = 1'b1;
            res_d.status = ST_EMPTY;
          end else begin
            ram_raddr = cnt_m1[AW-1:0];
            count_d   = cnt_m1;
          end
        end
      end
      S_INS_RD: begin
        // At the bottom of the store the new entry goes in directly.
        if (pos_q == '0) begin
          ram_we       = 1'b1;
          count_d      = count_q + CW'(1);
          done_d       = 1'b1;
          res_d.status = ST_INSERTED;
        end
      end
      S_INS_CMP: begin
        ram_we = 1'b1;
        if (rd_larger) begin
          ram_wdata = ram_rdata;
          pos_d     = pos_m1;
        end else begin
          count_d      = count_q + CW'(1);
          done_d       = 1'b1;
          res_d.status = ST_INSERTED;
        end
      end
      S_EXT_DATA: begin
        done_d            = 1'b1;
        res_d.status      = ST_EXTRACTED;
        res_d.out_key     = rd_key;
        res_d.out_payload = rd_pay_ext[PAY_W-1:0];
      end
      default: begin
        done_d = 1'b0;
      end
    endcase

    if (done_d) begin
      res_d.occupancy = OCC_W'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    key_q <= key_d;
    pay_q <= pay_d;
    res_q <= res_d;
  end

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

@@ sv/mpq_checker.sv @@
// Port-level checker for the max priority queue core, bound to the top level.
// Depends on mpq_pkg and on max_priority_queue_core.
`default_nettype none

module mpq_checker #(
  parameter int unsigned CAPACITY = mpq_pkg::DEF_CAPACITY
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               done_o,
  input mpq_pkg::out_item_t result_o
);

  import mpq_pkg::*;

  // Every accepted command is either answered at once or keeps the core busy.
  a_cmd_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || done_o))
    else $error("accepted command neither answered nor in progress");

  // Leaving the busy state always comes with a result.
  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("core went idle without a result");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_EMPTY) |-> (result_o.occupancy == '0))
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == ST_FULL) |-> (result_o.occupancy == OCC_W'(CAPACITY)))
    else $error("full status below capacity");

  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_EXTRACTED) |->
      (result_o.out_key == '0 && result_o.out_payload == '0))
    else $error("nonzero key or payload on a non-extract result");

endmodule

bind max_priority_queue_core mpq_checker #(
  .CAPACITY (CAPACITY)
) u_mpq_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for max_priority_queue_core: inserts and extracts
// checked against a sorted-list model of the queue. Depends on mpq_pkg and
// the core RTL only.
`timescale 1ns / 1ps

module tb;
  import mpq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = DEF_CAPACITY;
  // The slowest insert moves every held entry; sender gaps
  // and drain pauses stay far below this bound.
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned ITEM_TARGET = 1850;
  localparam int unsigned PRINT_LIMIT = 40;

  typedef struct {
    in_item_t item;
    bit       drain_first;  // hold this item back until all results are in
  } cmd_slot_t;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic        [PAY_W-1:0] payload;
  } held_entry_t;

  logic       clk_i;
  logic       rst_ni  = 1'b0;
  logic       start_i = 1'b0;
  in_item_t   item_i  = '0;
  logic       busy_o;
  logic       done_o;
  out_item_t  result_o;

  cmd_slot_t   cmd_backlog[$];
  out_item_t   expected_results[$];
  // Entries held by the queue, ascending by key, oldest first among equals,
  // so the next entry to leave is always at the back.
  held_entry_t sorted_entries[$];

  int unsigned error_count  = 0;
  int unsigned issued_count = 0;
  int unsigned quiet_cycles = 0;
  logic        taken_q      = 1'b0;

  max_priority_queue_core DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .item_i   (item_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Applies one command to the queue model and returns the result it yields.
  function automatic out_item_t apply_command(in_item_t cmd);
    out_item_t   res;
    held_entry_t ent;
    int          pos;
    res = '0;
    if (cmd.command == CMD_INSERT) begin
      if (sorted_entries.size() >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        ent.key     = cmd.key;
        ent.payload = cmd.payload;
        // Equal keys go above the older ones, so the newest leaves first.
        pos = sorted_entries.size();
        while (pos > 0 && $signed(sorted_entries[pos-1].key) > $signed(cmd.key)) pos--;
        sorted_entries.insert(pos, ent);
        res.status = ST_INSERTED;
      end
    end else if (sorted_entries.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      ent             = sorted_entries.pop_back();
      res.status      = ST_EXTRACTED;
      res.out_key     = ent.key;
      res.out_payload = ent.payload;
    end
    res.occupancy = OCC_W'(sorted_entries.size());
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with no command pending", 64'(got), '0);
    end else begin
      want = expected_results.pop_front();
      if (got.status != want.status)
        report_mismatch("status", 64'(got.status), 64'(want.status));
      if (got.out_key != want.out_key)
        report_mismatch("out_key", 64'(got.out_key), 64'(want.out_key));
      if (got.out_payload != want.out_payload)
        report_mismatch("out_payload", 64'(got.out_payload), 64'(want.out_payload));
      if (got.occupancy != want.occupancy)
        report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
    end
  endtask

  // Monitor: results are checked before a command taken on the same edge is
  // predicted, so the oldest expectation is always the one compared.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) check_result(result_o);
      if (start_i && !busy_o) expected_results.push_back(apply_command(item_i));
      taken_q <= start_i && !busy_o;
      if (done_o || (start_i && !busy_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("max_priority_queue_core regression: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Driver: an item stays on the bus until taken. Between items the sender
  // idles at random, except for a long stretch in the middle of the run.
  always @(negedge clk_i) begin
    cmd_slot_t slot;
    bit        idle_now;
    idle_now = !(issued_count >= 700 && issued_count < 1000) && $urandom_range(99) < 13;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !taken_q) begin
      start_i <= 1'b1;
    end else if (cmd_backlog.size() == 0 || idle_now ||
                 (cmd_backlog[0].drain_first && expected_results.size() != 0)) begin
      start_i <= 1'b0;
    end else begin
      slot = cmd_backlog.pop_front();
      start_i <= 1'b1;
      item_i  <= slot.item;
      issued_count++;
    end
  end

  task automatic queue_command(logic cmd, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay,
                               bit drain);
    cmd_slot_t slot;
    slot.item.command = cmd;
    slot.item.key     = key;
    slot.item.payload = pay;
    slot.drain_first  = drain;
    cmd_backlog.push_back(slot);
  endtask

  // Keys bunch near zero often enough to give many equal keys, and hit the
  // signed extremes now and then.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 25) return KEY_W'(int'($urandom_range(8)) - 4);
    if (roll < 40) begin
      case ($urandom_range(5))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        3:       return 32'hFFFF_FFFF;
        4:       return 32'h8000_0001;
        default: return 32'h7FFF_FFFE;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [PAY_W-1:0] pick_payload();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return PAY_W'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned insert_bias[5];
    int unsigned phase_idx;
    int unsigned random_count;
    int unsigned phase_len;
    int unsigned bias;

    insert_bias = '{85, 15, 50, 95, 5};

    // Directed part: extract from empty, signed extremes of the key, both
    // payload extremes, equal keys leaving newest first, then a full drain
    // ending in another extract from an empty queue.
    queue_command(CMD_EXTRACT, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    queue_command(CMD_INSERT,  32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    queue_command(CMD_INSERT,  32'h8000_0000, 16'h0000, 1'b0);
    queue_command(CMD_INSERT,  32'h0000_0000, 16'h0001, 1'b0);
    queue_command(CMD_INSERT,  32'hFFFF_FFFF, 16'hAAAA, 1'b0);
    queue_command(CMD_INSERT,  32'd5,         16'h0011, 1'b0);
    queue_command(CMD_INSERT,  32'd5,         16'h0022, 1'b0);
    queue_command(CMD_INSERT,  32'd5,         16'h0033, 1'b0);
    queue_command(CMD_INSERT,  32'h7FFF_FFFF, 16'h5555, 1'b0);
    for (int i = 0; i < 9; i++)
      queue_command(CMD_EXTRACT, (i % 2) ? 32'hFFFF_FFFF : 32'h0, (i % 2) ? 16'hFFFF : 16'h0,
                    1'b0);
    queue_command(CMD_EXTRACT, 32'h0, 16'h0, 1'b0);

    // Random part in phases, most of which lean toward inserts or extracts, so the
    // queue runs full and empty again and again. Every third phase starts
    // only after all outstanding results have come back.
    phase_idx    = 0;
    random_count = 0;
    while (random_count < ITEM_TARGET) begin
      bias      = insert_bias[phase_idx % 5];
      phase_len = $urandom_range(140, 60);
      for (int j = 0; j < phase_len && random_count < ITEM_TARGET; j++) begin
        queue_command(($urandom_range(99) < bias) ? CMD_INSERT : CMD_EXTRACT,
                      pick_key(), pick_payload(), j == 0 && phase_idx % 3 == 0);
        random_count++;
      end
      phase_idx++;
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_backlog.size() != 0 || start_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (2 * QUEUE_DEPTH + 16) @(posedge clk_i);

    if (error_count == 0) begin
      $display("max_priority_queue_core regression: pass");
    end else begin
      $display("max_priority_queue_core regression: fail");
    end
    $finish;
  end

endmodule
